// ===== rtl/htld_pkg.sv =====
// ----------------------------------------------------------------------------
// htld_pkg
// Shared sizes, codes and payload types of the Huffman tree loader/decoder.
// ----------------------------------------------------------------------------
package htld_pkg;

  localparam int MAX_LEAVES  = 256;
  localparam int SYMBOL_BITS = 8;
  localparam int SYM_W       = 8;
  localparam int NODE_DEPTH  = 2 * MAX_LEAVES - 1;
  localparam int STACK_DEPTH = MAX_LEAVES;
  localparam int NODE_W      = $clog2(NODE_DEPTH);
  localparam int COUNT_W     = $clog2(NODE_DEPTH + 1);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW      = $clog2(STACK_DEPTH);

  localparam logic [SYM_W-1:0] SYM_MASK = (SYMBOL_BITS >= SYM_W) ? {SYM_W{1'b1}} :
                                          SYM_W'((1 << SYMBOL_BITS) - 1);

  typedef enum logic [1:0] {
    REQ_SHAPE = 2'd0,
    REQ_CODE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SYMBOL   = 3'd1,
    ST_DONE     = 3'd2,
    ST_PHASE    = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_TRAILING = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             bit_value;
    logic [SYM_W-1:0] leaf_symbol;
    logic             last_bit;
  } htld_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SYM_W-1:0] symbol;
  } htld_out_t;

  // Child link kept in the parent entry, with the child's leaf flag and byte.
  typedef struct packed {
    logic [NODE_W-1:0] idx;
    logic              leaf;
    logic [SYM_W-1:0]  sym;
  } child_t;

  // Pending internal node and its left-child-filled flag.
  typedef struct packed {
    logic [NODE_W-1:0] idx;
    logic              filled;
  } stk_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [LVL_W-1:0]   level;
    stk_t               top;
    logic               tree_ready;
  } load_st_t;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic [LVL_W-1:0]   level;
    stk_t               top;
    logic               done;
    logic               root_we;
    logic               node_we;
    logic               node_right;
    logic [NODE_W-1:0]  node_addr;
    child_t             node_wdata;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_addr;
    stk_t               stk_wdata;
  } load_res_t;

endpackage

// ===== rtl/huffman_tree_load_and_decode.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Rebuilds a Huffman tree from preorder shape bits and decodes code bits.
//
//   channel  direction  payload     handshake
//   in       input      htld_in_t   in_valid_i / in_ready_o
//   out      output     htld_out_t  out_valid_o / out_ready_i
//
// One transaction per cycle sustained unless results stall; its result is
// registered after the input register, and the node table is read at the
// next walk node in that same cycle, so consecutive code bits need no gap.
// Reset clears the control state only; the node and stack tables keep their
// contents and need no clearing pass. A stalled result holds the input
// register; a new transaction is taken whenever the result moves on.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode
  import htld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  htld_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output htld_out_t out_data_o
);

  logic               in_vld_q;
  htld_in_t           in_q;
  logic               out_vld_q;
  htld_out_t          out_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [LVL_W-1:0]   level_q, level_d;
  stk_t               top_q, top_d;
  logic               ready_q, ready_d;
  logic [NODE_W-1:0]  walk_q, walk_d;
  logic               root_leaf_q;
  logic [SYM_W-1:0]   root_byte_q;

  logic       fire;
  logic       shape_fire;
  status_e    status_d;
  logic [SYM_W-1:0] sym_d;
  load_st_t   load_st;
  load_res_t  load_res;
  stk_t       stk_rd;
  child_t     left_rd;
  child_t     right_rd;
  child_t     child;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign shape_fire = fire && (in_q.req_type == REQ_SHAPE);

  assign load_st.count      = count_q;
  assign load_st.level      = level_q;
  assign load_st.top        = top_q;
  assign load_st.tree_ready = ready_q;

  htld_load u_load (
    .is_leaf_i (in_q.bit_value),
    .sym_i     (in_q.leaf_symbol),
    .st_i      (load_st),
    .stk_rd_i  (stk_rd),
    .res_o     (load_res)
  );

  htld_ram #(.DEPTH(NODE_DEPTH), .WIDTH($bits(child_t))) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (shape_fire && load_res.node_we && !load_res.node_right),
    .waddr_i (load_res.node_addr),
    .wdata_i (load_res.node_wdata),
    .raddr_i (walk_d),
    .rdata_o (left_rd)
  );

  htld_ram #(.DEPTH(NODE_DEPTH), .WIDTH($bits(child_t))) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (shape_fire && load_res.node_we && load_res.node_right),
    .waddr_i (load_res.node_addr),
    .wdata_i (load_res.node_wdata),
    .raddr_i (walk_d),
    .rdata_o (right_rd)
  );

  htld_ram #(.DEPTH(STACK_DEPTH), .WIDTH($bits(stk_t))) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (shape_fire && load_res.stk_we),
    .waddr_i (load_res.stk_addr),
    .wdata_i (load_res.stk_wdata),
    .raddr_i (STK_AW'(level_d - LVL_W'(2))),
    .rdata_o (stk_rd)
  );

  assign child = in_q.bit_value ? right_rd : left_rd;

  always_comb begin
    count_d  = count_q;
    level_d  = level_q;
    top_d    = top_q;
    ready_d  = ready_q;
    walk_d   = walk_q;
    status_d = ST_PHASE;
    sym_d    = '0;
    if (fire) begin
      case (in_q.req_type)
        REQ_SHAPE: begin
          status_d = load_res.status;
          count_d  = load_res.count;
          level_d  = load_res.level;
          top_d    = load_res.top;
          if (load_res.done) begin
            ready_d = 1'b1;
            walk_d  = '0;
          end
        end
        REQ_CODE: begin
          if (!ready_q) begin
            status_d = ST_PHASE;
          end else if (root_leaf_q) begin
            status_d = ST_SYMBOL;
            sym_d    = root_byte_q;
            walk_d   = '0;
          end else if (child.leaf) begin
            status_d = ST_SYMBOL;
            sym_d    = child.sym;
            walk_d   = '0;
          end else if (in_q.last_bit) begin
            status_d = ST_TRAILING;
            walk_d   = '0;
          end else begin
            status_d = ST_OK;
            walk_d   = child.idx;
          end
        end
        REQ_CLEAR: begin
          status_d = ST_OK;
          count_d  = '0;
          level_d  = '0;
          ready_d  = 1'b0;
          walk_d   = '0;
        end
        default: begin
          status_d = ST_PHASE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
      level_q   <= '0;
      ready_q   <= 1'b0;
      walk_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      count_q <= count_d;
      level_q <= level_d;
      ready_q <= ready_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q.status <= status_d;
      out_q.symbol <= sym_d;
    end
    top_q <= top_d;
    if (shape_fire && load_res.root_we) begin
      root_leaf_q <= in_q.bit_value;
      root_byte_q <= in_q.leaf_symbol & SYM_MASK;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/htld_ram.sv =====
// ----------------------------------------------------------------------------
// htld_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module htld_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/htld_load.sv =====
// ----------------------------------------------------------------------------
// htld_load
// Shape-bit step of the tree build: attach the new node to its pending
// parent, update the pending stack and report completion or errors.
// ----------------------------------------------------------------------------
module htld_load
  import htld_pkg::*;
(
  input  logic             is_leaf_i,
  input  logic [SYM_W-1:0] sym_i,
  input  load_st_t         st_i,
  input  stk_t             stk_rd_i,
  output load_res_t        res_o
);

  logic             pops;
  logic [LVL_W-1:0] lvl_after;
  stk_t             top_after;

  always_comb begin
    pops      = (st_i.count != '0) && st_i.top.filled;
    lvl_after = st_i.level;
    top_after = st_i.top;

    res_o                 = '0;
    res_o.status          = ST_OK;
    res_o.count           = st_i.count;
    res_o.level           = st_i.level;
    res_o.top             = st_i.top;
    res_o.node_addr       = st_i.top.idx;
    res_o.node_wdata.idx  = st_i.count[NODE_W-1:0];
    res_o.node_wdata.leaf = is_leaf_i;
    res_o.node_wdata.sym  = is_leaf_i ? (sym_i & SYM_MASK) : '0;
    res_o.stk_addr        = STK_AW'(st_i.level - 1'b1);
    res_o.stk_wdata       = st_i.top;

    if (st_i.tree_ready) begin
      res_o.status = ST_PHASE;
    end else if (st_i.count >= COUNT_W'(NODE_DEPTH)) begin
      res_o.status = ST_OVERFLOW;
    end else if ((st_i.count != '0) && (st_i.level == '0)) begin
      res_o.status = ST_PHASE;
    end else if (!is_leaf_i && !pops && (st_i.level >= LVL_W'(STACK_DEPTH))) begin
      res_o.status = ST_OVERFLOW;
    end else begin
      if (st_i.count == '0) begin
        res_o.root_we = 1'b1;
      end else begin
        res_o.node_we = 1'b1;
        if (!st_i.top.filled) begin
          top_after.filled = 1'b1;
        end else begin
          res_o.node_right = 1'b1;
          lvl_after        = LVL_W'(st_i.level - 1'b1);
          top_after        = stk_rd_i;
        end
      end
      res_o.count = COUNT_W'(st_i.count + 1'b1);
      if (!is_leaf_i) begin
        if ((st_i.count != '0) && !pops) begin
          res_o.stk_we    = 1'b1;
          res_o.stk_addr  = STK_AW'(lvl_after - 1'b1);
          res_o.stk_wdata = top_after;
        end
        res_o.top.idx    = st_i.count[NODE_W-1:0];
        res_o.top.filled = 1'b0;
        res_o.level      = LVL_W'(lvl_after + 1'b1);
      end else begin
        res_o.top   = top_after;
        res_o.level = lvl_after;
        if (lvl_after == '0) begin
          res_o.done   = 1'b1;
          res_o.status = ST_DONE;
        end
      end
    end
  end

endmodule

// ===== dv/htld_checker.sv =====
// ----------------------------------------------------------------------------
// htld_checker
// Watches both channels of the Huffman tree loader/decoder, predicts the
// status and symbol of every accepted input transaction from its own copy of
// the tree, stack and walk state, and compares each accepted result with the
// oldest prediction. Exposes the count of outstanding predictions and of
// mismatches to the testbench top.
// ----------------------------------------------------------------------------
module htld_checker
  import htld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  htld_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  htld_out_t   out_data_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [NODE_W-1:0]  kid_left       [NODE_DEPTH];
  logic [NODE_W-1:0]  kid_right      [NODE_DEPTH];
  logic               is_leaf        [NODE_DEPTH];
  logic [SYM_W-1:0]   leaf_byte      [NODE_DEPTH];
  logic [NODE_W-1:0]  open_idx       [STACK_DEPTH];
  logic               open_left_done [STACK_DEPTH];
  logic [LVL_W-1:0]   open_lvl;
  logic [COUNT_W-1:0] node_cnt;
  logic               tree_built;
  logic [NODE_W-1:0]  walk_at;

  htld_out_t   decoded_q [$];
  htld_out_t   want;
  int unsigned n_results;

  initial begin
    pending_o = 0;
    errors_o  = 0;
    n_results = 0;
  end

  task automatic flag_mismatch(input string what, input logic [SYM_W-1:0] exp_val,
                               input logic [SYM_W-1:0] got_val);
    $display("%0t ns: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
             $time, n_results, what, exp_val, got_val);
    errors_o++;
  endtask

  function automatic htld_out_t decode_step(input htld_in_t it);
    htld_out_t         res;
    logic              top_done;
    logic [NODE_W-1:0] slot;
    logic [NODE_W-1:0] nxt;
    res = '0;
    case (it.req_type)
      REQ_SHAPE: begin
        if (tree_built) begin
          res.status = ST_PHASE;
        end else if (node_cnt >= NODE_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (node_cnt != 0 && open_lvl == 0) begin
          res.status = ST_PHASE;
        end else begin
          top_done = (node_cnt != 0) && open_left_done[STK_AW'(open_lvl - 1'b1)];
          if (!it.bit_value && !top_done && open_lvl >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            slot = node_cnt[NODE_W-1:0];
            if (node_cnt != 0) begin
              if (!top_done) begin
                kid_left[open_idx[STK_AW'(open_lvl - 1'b1)]] = slot;
                open_left_done[STK_AW'(open_lvl - 1'b1)]     = 1'b1;
              end else begin
                kid_right[open_idx[STK_AW'(open_lvl - 1'b1)]] = slot;
                open_lvl                                      = open_lvl - 1'b1;
              end
            end
            is_leaf[slot]   = it.bit_value;
            leaf_byte[slot] = it.bit_value ? (it.leaf_symbol & SYM_MASK) : '0;
            kid_left[slot]  = '0;
            kid_right[slot] = '0;
            node_cnt        = node_cnt + 1'b1;
            if (!it.bit_value) begin
              open_idx[STK_AW'(open_lvl)]       = slot;
              open_left_done[STK_AW'(open_lvl)] = 1'b0;
              open_lvl                          = open_lvl + 1'b1;
              res.status                        = ST_OK;
            end else if (open_lvl == 0) begin
              tree_built = 1'b1;
              walk_at    = '0;
              res.status = ST_DONE;
            end else begin
              res.status = ST_OK;
            end
          end
        end
      end
      REQ_CODE: begin
        if (!tree_built) begin
          res.status = ST_PHASE;
        end else begin
          // a lone leaf at the root decodes on every bit
          nxt = is_leaf[0] ? '0 : (it.bit_value ? kid_right[walk_at] : kid_left[walk_at]);
          if (is_leaf[nxt]) begin
            res.status = ST_SYMBOL;
            res.symbol = leaf_byte[nxt];
            walk_at    = '0;
          end else if (it.last_bit) begin
            res.status = ST_TRAILING;
            walk_at    = '0;
          end else begin
            res.status = ST_OK;
            walk_at    = nxt;
          end
        end
      end
      REQ_CLEAR: begin
        open_lvl   = '0;
        node_cnt   = '0;
        tree_built = 1'b0;
        walk_at    = '0;
        res.status = ST_OK;
      end
      default: begin
        res.status = ST_PHASE;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_lvl   = '0;
      node_cnt   = '0;
      tree_built = 1'b0;
      walk_at    = '0;
      decoded_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        decoded_q.push_back(decode_step(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          flag_mismatch("unexpected", '0, SYM_W'(out_data_i.status));
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.status !== want.status) begin
            flag_mismatch("status", SYM_W'(want.status), SYM_W'(out_data_i.status));
          end
          if (out_data_i.symbol !== want.symbol) begin
            flag_mismatch("symbol", want.symbol, out_data_i.symbol);
          end
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// ===== dv/huffman_tree_load_and_decode_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_tb
// Drives preorder shape bits, code bits, clears and malformed requests into
// the Huffman tree loader/decoder with random gaps and output stalls: a
// directed opening, a run that fills the stack and the node table, then
// random trees with random code streams, noise and broken loads. The
// checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_tb
  import htld_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_TXNS = 110;
  localparam int unsigned LONG_HOLD   = 80;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  htld_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  htld_out_t out_data;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned sent = 0;
  bit          tx_idles = 1'b1;
  bit          rx_idles = 1'b1;
  bit          hold_rx = 1'b0;

  always #10 clk = ~clk;

  huffman_tree_load_and_decode u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  htld_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .pending_o  (pending),
    .errors_o   (mismatches)
  );

  function automatic logic [SYM_W-1:0] any_byte();
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_item(input logic [1:0] req, input logic bv,
                           input logic [SYM_W-1:0] sym, input logic last);
    int unsigned gap;
    gap = tx_idles ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, bit_value: bv, leaf_symbol: sym, last_bit: last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Emit a random full binary tree in preorder with the given leaf count.
  task automatic load_tree(input int unsigned leaves);
    int unsigned slots;
    int unsigned inner_left;
    bit          can_leaf;
    slots      = 1;
    inner_left = leaves - 1;
    while (slots != 0) begin
      can_leaf = (slots > 1) || (inner_left == 0);
      if (inner_left != 0 && (!can_leaf || $urandom_range(0, 1) == 1)) begin
        send_item(REQ_SHAPE, 1'b0, any_byte(), any_bit());
        inner_left--;
        slots++;
      end else begin
        send_item(REQ_SHAPE, 1'b1, any_byte(), any_bit());
        slots--;
      end
    end
  endtask

  task automatic decode_run(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(REQ_SHAPE, any_bit(), any_byte(), any_bit());
      end else begin
        send_item(REQ_CODE, any_bit(), any_byte(),
                  (i == n - 1) || ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        stall = rx_idles ? $urandom_range(0, 13) : 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  initial begin : stimulus
    int unsigned goal;
    int unsigned episode;
    int unsigned pick;
    rst_n    = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(REQ_CODE, 1'b0, any_byte(), 1'b0);
    send_item(REQ_UNUSED, any_bit(), any_byte(), any_bit());
    send_item(REQ_SHAPE, 1'b1, 8'hFF, 1'b0);
    send_item(REQ_CODE, 1'b0, any_byte(), 1'b0);
    send_item(REQ_CODE, 1'b1, any_byte(), 1'b1);
    send_item(REQ_SHAPE, 1'b0, any_byte(), 1'b0);
    send_item(REQ_CLEAR, any_bit(), any_byte(), any_bit());
    send_item(REQ_SHAPE, 1'b0, 8'h00, 1'b0);
    send_item(REQ_SHAPE, 1'b0, 8'hFF, 1'b1);
    send_item(REQ_SHAPE, 1'b1, 8'h00, 1'b0);
    send_item(REQ_SHAPE, 1'b1, 8'hA5, 1'b1);
    send_item(REQ_SHAPE, 1'b1, 8'h5A, 1'b0);
    send_item(REQ_CODE, 1'b1, 8'h00, 1'b0);
    send_item(REQ_CODE, 1'b0, 8'hFF, 1'b0);
    send_item(REQ_CODE, 1'b0, 8'h00, 1'b0);
    send_item(REQ_CODE, 1'b0, 8'h00, 1'b0);
    send_item(REQ_CODE, 1'b1, 8'h00, 1'b0);
    send_item(REQ_CODE, 1'b0, 8'h00, 1'b1);
    send_item(REQ_CODE, 1'b1, 8'h00, 1'b0);
    send_item(REQ_CODE, 1'b0, 8'h00, 1'b0);
    send_item(REQ_CODE, 1'b0, 8'h00, 1'b1);
    send_item(REQ_SHAPE, 1'b0, any_byte(), 1'b0);
    send_item(REQ_CLEAR, any_bit(), any_byte(), any_bit());
    send_item(REQ_SHAPE, 1'b1, 8'h80, 1'b0);
    send_item(REQ_UNUSED, any_bit(), any_byte(), any_bit());

    // fill the pending stack, overflow it, then fill the node table
    send_item(REQ_CLEAR, any_bit(), any_byte(), any_bit());
    repeat (STACK_DEPTH + 1) send_item(REQ_SHAPE, 1'b0, any_byte(), any_bit());
    send_item(REQ_SHAPE, 1'b1, any_byte(), any_bit());
    repeat ((NODE_DEPTH - STACK_DEPTH - 1) / 2) begin
      send_item(REQ_SHAPE, 1'b0, any_byte(), any_bit());
      send_item(REQ_SHAPE, 1'b1, any_byte(), any_bit());
    end
    send_item(REQ_SHAPE, 1'b1, any_byte(), any_bit());
    send_item(REQ_SHAPE, 1'b0, any_byte(), any_bit());
    send_item(REQ_CODE, any_bit(), any_byte(), any_bit());
    wait_drained();

    goal    = sent + RANDOM_TXNS;
    episode = 0;
    while (sent < goal) begin
      episode++;
      tx_idles = $urandom_range(0, 3) != 0;
      rx_idles = $urandom_range(0, 3) != 0;
      if (episode == 1) begin
        tx_idles = 1'b0;
        hold_rx  = 1'b1;
      end
      if (episode % 9 == 0) begin
        wait_drained();
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_item(REQ_CLEAR, any_bit(), any_byte(), any_bit());
        load_tree(pick < 2 ? $urandom_range(17, 64) : $urandom_range(1, 16));
        decode_run($urandom_range(4, 30));
      end else if (pick < 17) begin
        send_item(REQ_CLEAR, any_bit(), any_byte(), any_bit());
        repeat ($urandom_range(1, 6)) send_item(REQ_SHAPE, any_bit(), any_byte(), any_bit());
        decode_run($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(2'($urandom_range(0, 3)), any_bit(), any_byte(), any_bit());
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/htld_pkg.sv
rtl/htld_ram.sv
rtl/htld_load.sv
rtl/huffman_tree_load_and_decode.sv
dv/htld_checker.sv
dv/huffman_tree_load_and_decode_tb.sv
